@@ sv/bspq_pkg.sv @@
// types, constants and codes shared by the priority queue modules
package bspq_pkg;

    localparam int BSPQ_DEPTH   = 16;
    localparam int DATA_W       = 32;
    localparam int CFG_W        = 5;
    localparam int OUT_CNT_W    = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic signed [DATA_W-1:0]   item_value;
        logic signed [DATA_W-1:0]   item_priority;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   head_value;
        logic signed [DATA_W-1:0]   head_priority;
        logic [OUT_CNT_W-1:0]       entry_count;
        logic                       is_empty;
        logic                       is_full;
        logic                       rejected;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   value;
        logic signed [DATA_W-1:0]   prio;
    } slot_t;

    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

@@ sv/bspq_cell.sv @@
// one storage cell of the sorted shift chain
module bspq_cell import bspq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cell_ctrl_t  ctrl,
    input  slot_t       new_slot,
    input  logic        left_keep,
    input  logic        left_valid,
    input  slot_t       left_slot,
    input  logic        right_valid,
    input  slot_t       right_slot,
    output logic        valid,
    output slot_t       slot,
    output logic        keep,
    output logic        valid_nxt,
    output slot_t       slot_nxt
);

    logic  valid_reg;
    slot_t slot_reg;

    // equal priority stays ahead of a newcomer
    assign keep = valid_reg && (slot_reg.prio >= new_slot.prio);

    always_comb begin
        valid_nxt = valid_reg;
        slot_nxt  = slot_reg;
        if (ctrl.ins) begin
            if (!keep) begin
                valid_nxt = left_valid;
                slot_nxt  = left_keep ? new_slot : left_slot;
            end
        end else if (ctrl.rem) begin
            valid_nxt = right_valid;
            slot_nxt  = right_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_nxt;
        end
        slot_reg <= slot_nxt;
    end

    assign valid = valid_reg;
    assign slot  = slot_reg;

endmodule

@@ sv/bounded_stable_priority_queue.sv @@
// top level: sorted chain of cells with count, capacity and result register
//
//  channel  | ports                         | beat
//  ---------+-------------------------------+-------------------------------
//  input    | s_valid s_ready s_data        | insert pair or remove head
//  result   | m_valid m_ready m_data        | head, count and flags
//  config   | cfg_valid cfg_ready cfg_data  | max_entries
//
// one cycle per item: every cell compares its priority with the new one and
// shifts in the same edge; the result register is loaded on that edge and a
// new beat is taken while the result is being accepted. reset clears count and
// cell valid bits and sets capacity to the built depth, capped at CFG_MAX; a held result stalls
// the input side only.
module bounded_stable_priority_queue import bspq_pkg::*; #(
    parameter int DEPTH = BSPQ_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam int MAX_RESET = (DEPTH > CFG_MAX) ? CFG_MAX : DEPTH;

    logic [CFG_W-1:0]  max_entries_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic [CAP_W-1:0]  cap, count_ext, count_next_ext, max_ext;
    logic              accept, full_now, do_ins, do_rem;
    cell_ctrl_t        ctrl;
    slot_t             new_slot;

    logic              valid_w [DEPTH];
    slot_t             slot_w  [DEPTH];
    logic              keep_w  [DEPTH];
    logic              valid_n_w [DEPTH];
    slot_t             slot_n_w  [DEPTH];

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign max_ext   = CAP_W'(max_entries_reg);
    assign count_ext = CAP_W'(count_reg);

    always_comb begin
        if (max_ext == '0) begin
            cap = CAP_W'(1);
        end else if (max_ext > CAP_W'(DEPTH)) begin
            cap = CAP_W'(DEPTH);
        end else begin
            cap = max_ext;
        end
    end

    assign full_now = count_ext >= cap;
    assign do_ins   = accept && (s_data.kind == OP_INSERT) && !full_now;
    assign do_rem   = accept && (s_data.kind == OP_REMOVE) && (count_reg != '0);
    assign ctrl     = '{ins: do_ins, rem: do_rem};
    assign new_slot = '{value: s_data.item_value, prio: s_data.item_priority};

    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rem) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_next_ext = CAP_W'(count_next);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic  l_keep, l_valid, r_valid;
        slot_t l_slot, r_slot;

        if (i == 0) begin : g_first
            assign l_keep  = 1'b1;
            assign l_valid = 1'b1;
            assign l_slot  = new_slot;
        end else begin : g_mid
            assign l_keep  = keep_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_slot  = slot_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_valid = 1'b0;
            assign r_slot  = slot_w[i];
        end else begin : g_inner
            assign r_valid = valid_w[i+1];
            assign r_slot  = slot_w[i+1];
        end

        bspq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_slot    (new_slot),
            .left_keep   (l_keep),
            .left_valid  (l_valid),
            .left_slot   (l_slot),
            .right_valid (r_valid),
            .right_slot  (r_slot),
            .valid       (valid_w[i]),
            .slot        (slot_w[i]),
            .keep        (keep_w[i]),
            .valid_nxt   (valid_n_w[i]),
            .slot_nxt    (slot_n_w[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= CFG_W'(MAX_RESET);
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_entries_reg <= cfg_data;
            end
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_data_reg.head_value    <= valid_n_w[0] ? slot_n_w[0].value : '0;
            m_data_reg.head_priority <= valid_n_w[0] ? slot_n_w[0].prio : '0;
            m_data_reg.entry_count   <= OUT_CNT_W'(count_next_ext);
            m_data_reg.is_empty      <= count_next == '0;
            m_data_reg.is_full       <= count_next_ext >= cap;
            m_data_reg.rejected      <= (s_data.kind == OP_INSERT) && full_now;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ sv/bspq_checker.sv @@
// port level checks for the priority queue, bound to the top level
module bspq_checker import bspq_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input in_item_t   s_data,
    input logic       m_valid,
    input logic       m_ready,
    input out_item_t  m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_empty |->
            m_data.head_value == '0 && m_data.head_priority == '0 &&
            m_data.entry_count == '0 && !m_data.is_full)
        else $error("empty result not cleared");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rejected |-> m_data.is_full)
        else $error("reject without full");

    a_remove_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == OP_REMOVE |=> m_valid && !m_data.rejected)
        else $error("remove beat gave no clean result");

    a_input_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat gave no result");

endmodule

bind bounded_stable_priority_queue bspq_checker u_bspq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
